// ===== src/psim_pkg.sv =====
// shared constants, types and helpers for the profile similarity block
package psim_pkg;

	localparam int NPROF   = 64;
	localparam int PROF_W  = 6;
	localparam int NLIKE   = 32;
	localparam int LIKE_W  = 5;
	localparam int CNT_W   = 6;
	localparam int ID_W    = 16;
	localparam int NTOP    = 8;
	localparam int TOP_W   = 3;
	localparam int LEN_W   = 4;
	localparam int SCORE_W = 6;
	localparam int AVG_W   = 7;
	localparam int PC_W    = 7;
	localparam int SUM_W   = 17;
	localparam int NUM_W   = 11;
	localparam int DVD_W   = 18;
	localparam int TC_W    = 4;

	localparam logic [1:0] MODE_ADD   = 2'd0;
	localparam logic [1:0] MODE_CLOSE = 2'd1;
	localparam logic [1:0] MODE_QUERY = 2'd2;

	localparam logic [TC_W-1:0] TOP_COUNT_RESET = 4'd5;

	typedef struct packed {
		logic              clr;
		logic              ins;
		logic [LEN_W-1:0]  limit;
	} tl_ctrl_t;

	// register value clamped to 1..NTOP
	function automatic logic [LEN_W-1:0] eff_limit(input logic [TC_W-1:0] tc);
		logic [LEN_W-1:0] n;
		n = tc;
		if (n < LEN_W'(1)) n = LEN_W'(1);
		if (n > LEN_W'(NTOP)) n = LEN_W'(NTOP);
		return n;
	endfunction

endpackage

// ===== src/psim_div.sv =====
// restoring divider, one quotient bit per cycle
module psim_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [psim_pkg::DVD_W-1:0] dividend,
	input  logic [psim_pkg::NUM_W-1:0] divisor,
	output logic                       done,
	output logic [psim_pkg::DVD_W-1:0] quotient
);
	import psim_pkg::*;

	localparam int ITER_W = $clog2(DVD_W);

	logic              run_q;
	logic              done_q;
	logic [ITER_W-1:0] iter_q;
	logic [NUM_W-1:0]  rem_q;
	logic [NUM_W-1:0]  dsr_q;
	logic [DVD_W-1:0]  dq_q;
	logic [NUM_W:0]    rem_sh;
	logic              qbit;
	logic [NUM_W:0]    rem_sub;

	always_comb begin
		rem_sh  = {rem_q, dq_q[DVD_W-1]};
		qbit    = rem_sh >= {1'b0, dsr_q};
		rem_sub = rem_sh - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				iter_q <= '0;
			end else if (run_q) begin
				iter_q <= iter_q + ITER_W'(1);
				if (iter_q == ITER_W'(DVD_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			dq_q  <= dividend;
		end else if (run_q) begin
			rem_q <= qbit ? rem_sub[NUM_W-1:0] : rem_sh[NUM_W-1:0];
			dq_q  <= {dq_q[DVD_W-2:0], qbit};
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule

// ===== src/psim_toplist.sv =====
// working neighbour list of one profile with sorted insertion
module psim_toplist (
	input  logic                         clk,
	input  logic                         arst_n,
	input  psim_pkg::tl_ctrl_t           ctrl,
	input  logic [psim_pkg::SCORE_W-1:0] score,
	input  logic [psim_pkg::PROF_W-1:0]  nbr,
	input  logic [psim_pkg::TOP_W-1:0]   rd_idx,
	output logic [psim_pkg::LEN_W-1:0]   len,
	output logic [psim_pkg::PROF_W-1:0]  rd_nbr,
	output logic [psim_pkg::SCORE_W-1:0] rd_score
);
	import psim_pkg::*;

	logic [PROF_W-1:0]  nb_q [NTOP];
	logic [SCORE_W-1:0] sc_q [NTOP];
	logic [LEN_W-1:0]   len_q;
	logic [LEN_W-1:0]   pos;
	logic [LEN_W-1:0]   new_len;
	logic               take;

	// entries at or above the new score form a prefix, ties keep the earlier one
	always_comb begin
		pos = '0;
		for (int k = 0; k < NTOP; k++) begin
			if (LEN_W'(k) < len_q && sc_q[k] >= score) pos = pos + LEN_W'(1);
		end
		take    = ctrl.ins && (pos < ctrl.limit);
		new_len = (len_q < ctrl.limit) ? len_q + LEN_W'(1) : len_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (ctrl.clr) begin
			len_q <= '0;
		end else if (take) begin
			len_q <= new_len;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (pos == '0) begin
				nb_q[0] <= nbr;
				sc_q[0] <= score;
			end
			for (int k = 1; k < NTOP; k++) begin
				if (LEN_W'(k) == pos) begin
					nb_q[k] <= nbr;
					sc_q[k] <= score;
				end else if (LEN_W'(k) > pos) begin
					nb_q[k] <= nb_q[k-1];
					sc_q[k] <= sc_q[k-1];
				end
			end
		end
	end

	assign len      = len_q;
	assign rd_nbr   = nb_q[rd_idx];
	assign rd_score = sc_q[rd_idx];

endmodule

// ===== src/profile_similarity_top_n_core.sv =====
// top level: profile intake, pairwise merge sequencer, average, neighbour lists, queries
//
// channel   direction  beat marker          payload
// command   in         start && !busy       mode, like_id, last_in_profile, last_profile,
//                                           query_profile
// config    in         cfg_we               cfg_wdata (top_count)
// result    out        done (one cycle)     profile, rank, neighbour, capped_common,
//                                           avg_threshold, found, short_list, last
//
// an add or close beat leaves busy low, unless it closes the final profile: then the
// merge sequencer runs n(n-1)/2 pairs for the average, a divide, then n(n-1) pairs for
// the lists; a pair takes at most na+nb-1 merge steps on the two read ports of the like
// memory, and each profile then stores its list. after a query beat the sequencer
// passes S_Q_LEN and S_Q_FIRST (which gives the result for an empty list), then S_Q_RD
// and S_Q_OUT for each list entry, limited by the registered reads of the list
// memories; busy drops as the last result appears. reset clears all control state;
// the memories are tracked by fill counts and need no clearing. results cannot be
// stalled: each one sits on the ports for exactly one cycle.
module profile_similarity_top_n_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   mode,
	input  logic [psim_pkg::ID_W-1:0]    like_id,
	input  logic                         last_in_profile,
	input  logic                         last_profile,
	input  logic [psim_pkg::PROF_W-1:0]  query_profile,
	input  logic                         cfg_we,
	input  logic [psim_pkg::TC_W-1:0]    cfg_wdata,
	output logic                         done,
	output logic [psim_pkg::PROF_W-1:0]  profile,
	output logic [psim_pkg::TOP_W-1:0]   rank,
	output logic [psim_pkg::PROF_W-1:0]  neighbour,
	output logic [psim_pkg::SCORE_W-1:0] capped_common,
	output logic [psim_pkg::AVG_W-1:0]   avg_threshold,
	output logic                         found,
	output logic                         short_list,
	output logic                         last
);
	import psim_pkg::*;

	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_C_START   = 4'd1;
	localparam logic [3:0] S_PR_LEN    = 4'd2;
	localparam logic [3:0] S_PR_INIT   = 4'd3;
	localparam logic [3:0] S_M_RD      = 4'd4;
	localparam logic [3:0] S_M_CMP     = 4'd5;
	localparam logic [3:0] S_PAIR_DONE = 4'd6;
	localparam logic [3:0] S_DIV_START = 4'd7;
	localparam logic [3:0] S_DIV_WAIT  = 4'd8;
	localparam logic [3:0] S_P2_PROF   = 4'd9;
	localparam logic [3:0] S_P2_NEXTQ  = 4'd10;
	localparam logic [3:0] S_WR_LIST   = 4'd11;
	localparam logic [3:0] S_Q_LEN     = 4'd12;
	localparam logic [3:0] S_Q_FIRST   = 4'd13;
	localparam logic [3:0] S_Q_RD      = 4'd14;
	localparam logic [3:0] S_Q_OUT     = 4'd15;

	// control state
	logic [3:0]        state_q;
	logic [PC_W-1:0]   pc_q;
	logic [CNT_W-1:0]  cur_cnt_q;
	logic              ready_q;
	logic              phase2_q;
	logic [TC_W-1:0]   top_count_q;
	logic [PC_W-1:0]   p_q;
	logic [PC_W-1:0]   q_q;
	logic [CNT_W-1:0]  i_q;
	logic [CNT_W-1:0]  j_q;
	logic [CNT_W-1:0]  na_q;
	logic [CNT_W-1:0]  nb_q;
	logic [CNT_W-1:0]  c_q;
	logic [SUM_W-1:0]  sum_q;
	logic [NUM_W-1:0]  num_q;
	logic [AVG_W-1:0]  avg_q;
	logic [LEN_W-1:0]  k_q;
	logic [PROF_W-1:0] qp_q;
	logic [LEN_W-1:0]  qlen_q;
	logic              done_q;

	// memories and their registered read data
	logic [ID_W-1:0]    like_mem [NPROF*NLIKE];
	logic [CNT_W-1:0]   cnt_mem  [NPROF];
	logic [PROF_W-1:0]  nb_mem   [NPROF*NTOP];
	logic [SCORE_W-1:0] sc_mem   [NPROF*NTOP];
	logic [LEN_W-1:0]   len_mem  [NPROF];
	logic [ID_W-1:0]    la_q;
	logic [ID_W-1:0]    lb_q;
	logic [CNT_W-1:0]   ca_q;
	logic [CNT_W-1:0]   cb_q;
	logic [PROF_W-1:0]  rnb_q;
	logic [SCORE_W-1:0] rsc_q;
	logic [LEN_W-1:0]   rlen_q;

	// result payload
	logic [PROF_W-1:0]  profile_q;
	logic [TOP_W-1:0]   rank_q;
	logic [PROF_W-1:0]  neighbour_q;
	logic [SCORE_W-1:0] capped_q;
	logic [AVG_W-1:0]   avgout_q;
	logic               found_q;
	logic               short_q;
	logic               last_q;

	// intake decode
	logic              accept;
	logic              intake;
	logic [PC_W-1:0]   pc_base;
	logic [CNT_W-1:0]  cnt_base;
	logic              room;
	logic              store;
	logic              closing;
	logic              close_wr;
	logic [CNT_W-1:0]  new_cnt;

	// pair score, list engine, divider
	logic [SCORE_W-1:0] score;
	logic [LEN_W-1:0]   limit;
	tl_ctrl_t           tl_ctrl;
	logic [LEN_W-1:0]   tl_len;
	logic [PROF_W-1:0]  tl_nbr;
	logic [SCORE_W-1:0] tl_score;
	logic               div_start;
	logic               div_done;
	logic [DVD_W-1:0]   div_dvd;
	logic [DVD_W-1:0]   div_quot;
	logic               list_wr;
	logic [LEN_W-1:0]   q_len;

	assign busy   = state_q != S_IDLE;
	assign accept = start && !busy;
	assign intake = accept && (mode == MODE_ADD || mode == MODE_CLOSE);
	assign limit  = eff_limit(top_count_q);

	// intake after a finished computation starts a new set
	always_comb begin
		pc_base  = ready_q ? '0 : pc_q;
		cnt_base = ready_q ? '0 : cur_cnt_q;
		room     = pc_base < PC_W'(NPROF);
		closing  = (mode == MODE_CLOSE) || last_in_profile;
		store    = intake && (mode == MODE_ADD) && room && (cnt_base < CNT_W'(NLIKE));
		close_wr = intake && room && closing;
		new_cnt  = cnt_base + CNT_W'(store);
	end

	// score capped at the average; a count above avg only happens when avg fits the field
	assign score = ({1'b0, c_q} < avg_q) ? c_q : avg_q[SCORE_W-1:0];

	// list length seen by a query
	assign q_len = (ready_q && ({1'b0, qp_q} < pc_q)) ? rlen_q : '0;

	always_comb begin
		tl_ctrl.clr   = (state_q == S_P2_PROF) && (p_q != pc_q);
		tl_ctrl.ins   = (state_q == S_PAIR_DONE) && phase2_q && (score != '0);
		tl_ctrl.limit = limit;
	end

	assign div_start = (state_q == S_DIV_START) && (num_q != '0);
	assign div_dvd   = {sum_q, 1'b0} + DVD_W'(num_q) - DVD_W'(1);
	assign list_wr   = (state_q == S_WR_LIST) && (k_q != tl_len);

	psim_toplist u_list (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (tl_ctrl),
		.score    (score),
		.nbr      (q_q[PROF_W-1:0]),
		.rd_idx   (k_q[TOP_W-1:0]),
		.len      (tl_len),
		.rd_nbr   (tl_nbr),
		.rd_score (tl_score)
	);

	psim_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (num_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	// like store: one write port, two read ports for the merge
	always_ff @(posedge clk) begin
		if (store) like_mem[{pc_base[PROF_W-1:0], cnt_base[LIKE_W-1:0]}] <= like_id;
		la_q <= like_mem[{p_q[PROF_W-1:0], i_q[LIKE_W-1:0]}];
		lb_q <= like_mem[{q_q[PROF_W-1:0], j_q[LIKE_W-1:0]}];
	end

	// per profile like counts, written when a profile closes
	always_ff @(posedge clk) begin
		if (close_wr) cnt_mem[pc_base[PROF_W-1:0]] <= new_cnt;
		ca_q <= cnt_mem[p_q[PROF_W-1:0]];
		cb_q <= cnt_mem[q_q[PROF_W-1:0]];
	end

	// stored neighbour lists
	always_ff @(posedge clk) begin
		if (list_wr) begin
			nb_mem[{p_q[PROF_W-1:0], k_q[TOP_W-1:0]}] <= tl_nbr;
			sc_mem[{p_q[PROF_W-1:0], k_q[TOP_W-1:0]}] <= tl_score;
		end
		rnb_q <= nb_mem[{qp_q, k_q[TOP_W-1:0]}];
		rsc_q <= sc_mem[{qp_q, k_q[TOP_W-1:0]}];
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_WR_LIST) && (k_q == tl_len)) len_mem[p_q[PROF_W-1:0]] <= tl_len;
		rlen_q <= len_mem[qp_q];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pc_q        <= '0;
			cur_cnt_q   <= '0;
			ready_q     <= 1'b0;
			phase2_q    <= 1'b0;
			top_count_q <= TOP_COUNT_RESET;
			p_q         <= '0;
			q_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			na_q        <= '0;
			nb_q        <= '0;
			c_q         <= '0;
			sum_q       <= '0;
			num_q       <= '0;
			avg_q       <= '0;
			k_q         <= '0;
			qp_q        <= '0;
			qlen_q      <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) top_count_q <= cfg_wdata;
			case (state_q)
				S_IDLE: begin
					if (intake) begin
						if (ready_q) begin
							ready_q <= 1'b0;
							avg_q   <= '0;
						end
						pc_q      <= close_wr ? pc_base + PC_W'(1) : pc_base;
						cur_cnt_q <= close_wr ? '0 : new_cnt;
						if (closing && last_profile) state_q <= S_C_START;
					end else if (accept && mode == MODE_QUERY) begin
						qp_q    <= query_profile;
						state_q <= S_Q_LEN;
					end
				end
				S_C_START: begin
					phase2_q <= 1'b0;
					sum_q    <= '0;
					num_q    <= '0;
					p_q      <= '0;
					q_q      <= PC_W'(1);
					state_q  <= (pc_q < PC_W'(2)) ? S_DIV_START : S_PR_LEN;
				end
				S_PR_LEN: begin
					state_q <= S_PR_INIT;
				end
				S_PR_INIT: begin
					na_q    <= ca_q;
					nb_q    <= cb_q;
					i_q     <= '0;
					j_q     <= '0;
					c_q     <= '0;
					state_q <= S_M_RD;
				end
				S_M_RD: begin
					state_q <= (i_q < na_q && j_q < nb_q) ? S_M_CMP : S_PAIR_DONE;
				end
				S_M_CMP: begin
					if (la_q == lb_q) begin
						c_q <= c_q + CNT_W'(1);
						i_q <= i_q + CNT_W'(1);
						j_q <= j_q + CNT_W'(1);
					end else if (la_q > lb_q) begin
						j_q <= j_q + CNT_W'(1);
					end else begin
						i_q <= i_q + CNT_W'(1);
					end
					state_q <= S_M_RD;
				end
				S_PAIR_DONE: begin
					if (phase2_q) begin
						q_q     <= q_q + PC_W'(1);
						state_q <= S_P2_NEXTQ;
					end else begin
						if (c_q != '0) begin
							sum_q <= sum_q + SUM_W'(c_q);
							num_q <= num_q + NUM_W'(1);
						end
						if (q_q + PC_W'(1) < pc_q) begin
							q_q     <= q_q + PC_W'(1);
							state_q <= S_PR_LEN;
						end else if (p_q + PC_W'(2) < pc_q) begin
							p_q     <= p_q + PC_W'(1);
							q_q     <= p_q + PC_W'(2);
							state_q <= S_PR_LEN;
						end else begin
							state_q <= S_DIV_START;
						end
					end
				end
				S_DIV_START: begin
					if (num_q == '0) begin
						avg_q    <= '0;
						p_q      <= '0;
						phase2_q <= 1'b1;
						state_q  <= S_P2_PROF;
					end else begin
						state_q <= S_DIV_WAIT;
					end
				end
				S_DIV_WAIT: begin
					if (div_done) begin
						avg_q    <= div_quot[AVG_W-1:0];
						p_q      <= '0;
						phase2_q <= 1'b1;
						state_q  <= S_P2_PROF;
					end
				end
				S_P2_PROF: begin
					if (p_q == pc_q) begin
						ready_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						q_q     <= '0;
						state_q <= S_P2_NEXTQ;
					end
				end
				S_P2_NEXTQ: begin
					if (q_q == pc_q) begin
						k_q     <= '0;
						state_q <= S_WR_LIST;
					end else if (q_q == p_q) begin
						q_q <= q_q + PC_W'(1);
					end else begin
						state_q <= S_PR_LEN;
					end
				end
				S_WR_LIST: begin
					if (k_q == tl_len) begin
						p_q     <= p_q + PC_W'(1);
						state_q <= S_P2_PROF;
					end else begin
						k_q <= k_q + LEN_W'(1);
					end
				end
				S_Q_LEN: begin
					state_q <= S_Q_FIRST;
				end
				S_Q_FIRST: begin
					qlen_q <= q_len;
					k_q    <= '0;
					if (q_len == '0) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_Q_RD;
					end
				end
				S_Q_RD: begin
					state_q <= S_Q_OUT;
				end
				S_Q_OUT: begin
					done_q  <= 1'b1;
					k_q     <= k_q + LEN_W'(1);
					state_q <= (k_q + LEN_W'(1) == qlen_q) ? S_IDLE : S_Q_RD;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result payload: empty list beat or one list entry beat
	always_ff @(posedge clk) begin
		if (state_q == S_Q_FIRST && q_len == '0) begin
			profile_q   <= qp_q;
			rank_q      <= '0;
			neighbour_q <= '0;
			capped_q    <= '0;
			avgout_q    <= ready_q ? avg_q : '0;
			found_q     <= 1'b0;
			short_q     <= 1'b1;
			last_q      <= 1'b1;
		end else if (state_q == S_Q_OUT) begin
			profile_q   <= qp_q;
			rank_q      <= k_q[TOP_W-1:0];
			neighbour_q <= rnb_q;
			capped_q    <= rsc_q;
			avgout_q    <= avg_q;
			found_q     <= 1'b1;
			short_q     <= qlen_q < limit;
			last_q      <= (k_q + LEN_W'(1) == qlen_q);
		end
	end

	assign done          = done_q;
	assign profile       = profile_q;
	assign rank          = rank_q;
	assign neighbour     = neighbour_q;
	assign capped_common = capped_q;
	assign avg_threshold = avgout_q;
	assign found         = found_q;
	assign short_list    = short_q;
	assign last          = last_q;

	// a listed neighbour never scores above the average threshold
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		done && found |-> {1'b0, capped_common} <= avg_threshold)
		else $error("score above average threshold");

	// only nonzero scores enter a list
	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done && found |-> capped_common != '0)
		else $error("zero score in neighbour list");

	// an empty list is a single final short beat
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done && !found |-> last && short_list && rank == '0)
		else $error("malformed empty list beat");

	// result beats come only while a query drains or just after it
	a_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_Q_OUT || state_q == S_Q_FIRST))
		else $error("result beat outside a query");

endmodule

// ===== verif/profile_similarity_top_n_core_test.sv =====
// testbench for profile_similarity_top_n_core: directed and random profile sets, self-checking
module profile_similarity_top_n_core_test;
	import psim_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int MAX_GAP = 12;

	// expected neighbour list entry as it appears on the result ports
	typedef struct packed {
		logic [PROF_W-1:0]  profile;
		logic [TOP_W-1:0]   rank;
		logic [PROF_W-1:0]  neighbour;
		logic [SCORE_W-1:0] capped_common;
		logic [AVG_W-1:0]   avg_threshold;
		logic               found;
		logic               short_list;
		logic               last;
	} list_entry_t;

	logic clk, arst_n, start, busy;
	logic [1:0] mode;
	logic [ID_W-1:0] like_id;
	logic last_in_profile, last_profile;
	logic [PROF_W-1:0] query_profile;
	logic cfg_we;
	logic [TC_W-1:0] cfg_wdata;
	logic done;
	logic [PROF_W-1:0] profile;
	logic [TOP_W-1:0] rank;
	logic [PROF_W-1:0] neighbour;
	logic [SCORE_W-1:0] capped_common;
	logic [AVG_W-1:0] avg_threshold;
	logic found, short_list, last;

	profile_similarity_top_n_core i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.mode(mode), .like_id(like_id), .last_in_profile(last_in_profile),
		.last_profile(last_profile), .query_profile(query_profile),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done),
		.profile(profile), .rank(rank), .neighbour(neighbour),
		.capped_common(capped_common), .avg_threshold(avg_threshold),
		.found(found), .short_list(short_list), .last(last)
	);

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	// shadow copy of the block state
	logic [ID_W-1:0]    sh_likes [NPROF][NLIKE];
	int unsigned        sh_like_cnt [NPROF];
	int unsigned        sh_prof_cnt;
	logic [PROF_W-1:0]  sh_nbr [NPROF][NTOP];
	logic [SCORE_W-1:0] sh_score [NPROF][NTOP];
	int unsigned        sh_len [NPROF];
	int unsigned        sh_avg;
	bit                 sh_ready;
	logic [TC_W-1:0]    sh_top_count;

	list_entry_t pending_entries[$];
	int errors, beats_sent, entries_seen, sets_built, cycles;
	bit no_gaps;

	function automatic int unsigned keep_limit();
		int unsigned n;
		n = sh_top_count;
		if (n < 1) n = 1;
		if (n > NTOP) n = NTOP;
		return n;
	endfunction

	// merge count of ids shared by two stored profiles
	function automatic int unsigned shared_likes(int unsigned a, int unsigned b);
		int unsigned i, j, c;
		i = 0; j = 0; c = 0;
		while (i < sh_like_cnt[a] && j < sh_like_cnt[b]) begin
			if (sh_likes[a][i] == sh_likes[b][j]) begin
				c++; i++; j++;
			end else if (sh_likes[a][i] > sh_likes[b][j]) begin
				j++;
			end else begin
				i++;
			end
		end
		return c;
	endfunction

	function automatic void rank_neighbours();
		longint unsigned sum, num;
		int unsigned lim, c, s, pos, len;
		sum = 0; num = 0;
		lim = keep_limit();
		for (int p = 0; p < sh_prof_cnt; p++)
			for (int q = p + 1; q < sh_prof_cnt; q++) begin
				c = shared_likes(p, q);
				if (c != 0) begin
					sum += c; num++;
				end
			end
		sh_avg = (num != 0) ? int'((2 * sum + num - 1) / num) : 0;
		for (int p = 0; p < sh_prof_cnt; p++) begin
			len = 0;
			for (int q = 0; q < sh_prof_cnt; q++) begin
				if (q == p) continue;
				c = shared_likes(p, q);
				s = (c < sh_avg) ? c : sh_avg;
				if (s == 0) continue;
				pos = 0;
				while (pos < len && sh_score[p][pos] >= s) pos++;
				if (pos >= lim) continue;
				if (len < lim) len++;
				for (int k = len - 1; k > pos; k--) begin
					sh_nbr[p][k] = sh_nbr[p][k-1];
					sh_score[p][k] = sh_score[p][k-1];
				end
				sh_nbr[p][pos] = q[PROF_W-1:0];
				sh_score[p][pos] = s[SCORE_W-1:0];
			end
			sh_len[p] = len;
		end
		sh_ready = 1'b1;
	endfunction

	function automatic void drop_set();
		for (int p = 0; p < NPROF; p++) begin
			sh_like_cnt[p] = 0;
			sh_len[p] = 0;
		end
		sh_prof_cnt = 0;
		sh_avg = 0;
		sh_ready = 1'b0;
	endfunction

	// advance the shadow state by one accepted beat and queue its list entries
	function automatic void predict_beat(logic [1:0] md, logic [ID_W-1:0] id, bit lip, bit lp,
			logic [PROF_W-1:0] qp);
		bit closing;
		int unsigned len, p;
		list_entry_t e;
		if (md == MODE_ADD || md == MODE_CLOSE) begin
			closing = (md == MODE_CLOSE) || lip;
			if (sh_ready) drop_set();
			if (sh_prof_cnt < NPROF) begin
				p = sh_prof_cnt;
				if (md == MODE_ADD && sh_like_cnt[p] < NLIKE) begin
					sh_likes[p][sh_like_cnt[p]] = id;
					sh_like_cnt[p]++;
				end
				if (closing) sh_prof_cnt++;
			end
			if (closing && lp) rank_neighbours();
		end else if (md == MODE_QUERY) begin
			len = (sh_ready && qp < sh_prof_cnt) ? sh_len[qp] : 0;
			if (len == 0) begin
				e = '0;
				e.profile = qp;
				e.avg_threshold = sh_ready ? sh_avg[AVG_W-1:0] : '0;
				e.short_list = 1'b1;
				e.last = 1'b1;
				pending_entries = {pending_entries, e};
			end else begin
				for (int k = 0; k < len; k++) begin
					e.profile = qp;
					e.rank = k[TOP_W-1:0];
					e.neighbour = sh_nbr[qp][k];
					e.capped_common = sh_score[qp][k];
					e.avg_threshold = sh_avg[AVG_W-1:0];
					e.found = 1'b1;
					e.short_list = len < keep_limit();
					e.last = (k + 1 == len);
					pending_entries = {pending_entries, e};
				end
			end
		end
	endfunction

	function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
			errors++;
		end
	endfunction

	// result checker: every done cycle is compared with the oldest expectation
	always @(posedge clk) begin
		list_entry_t e;
		if (arst_n && done) begin
			entries_seen++;
			if (pending_entries.size() == 0) begin
				$display("%0t: unexpected result, profile %0d rank %0d neighbour %0d",
					$time, profile, rank, neighbour);
				errors++;
			end else begin
				e = pending_entries.pop_front();
				check_field("profile", e.profile, profile);
				check_field("rank", e.rank, rank);
				check_field("neighbour", e.neighbour, neighbour);
				check_field("capped_common", e.capped_common, capped_common);
				check_field("avg_threshold", e.avg_threshold, avg_threshold);
				check_field("found", e.found, found);
				check_field("short_list", e.short_list, short_list);
				check_field("last", e.last, last);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// one command beat: random hold-off, then hold start until the block takes it
	task automatic send_beat(logic [1:0] md, logic [ID_W-1:0] id, bit lip, bit lp,
			logic [PROF_W-1:0] qp);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		mode <= md;
		like_id <= id;
		last_in_profile <= lip;
		last_profile <= lp;
		query_profile <= qp;
		do @(posedge clk); while (busy);
		predict_beat(md, id, lip, lp, qp);
		beats_sent++;
	endtask

	task automatic send_profile(logic [ID_W-1:0] ids[$], bit final_one);
		if (ids.size() == 0) begin
			send_beat(MODE_CLOSE, $urandom, $urandom_range(0, 1), final_one, $urandom);
		end else begin
			for (int i = 0; i < ids.size(); i++)
				send_beat(MODE_ADD, ids[i], i == ids.size() - 1,
					(i == ids.size() - 1) ? final_one : bit'($urandom_range(0, 1)), $urandom);
		end
	endtask

	task automatic send_query(logic [PROF_W-1:0] qp);
		send_beat(MODE_QUERY, $urandom, $urandom_range(0, 1), $urandom_range(0, 1), qp);
	endtask

	// hold the sender until every expected entry is out and the block is idle again
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending_entries.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		while (busy) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_top_count(logic [TC_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		sh_top_count = v;
	endtask

	task automatic query_all(int unsigned n);
		for (int q = 0; q < n; q++) send_query(q[PROF_W-1:0]);
	endtask

	// queries before any set exists, and the ignored unused mode
	task automatic test_idle_queries();
		send_query('0);
		send_query('1);
		send_beat(MODE_UNUSED, '1, 1'b1, 1'b1, '1);
		send_query(6'd5);
	endtask

	// small hand-built set: id extremes, empty profile, unsorted ids, ties
	task automatic test_directed_set();
		logic [ID_W-1:0] ids[$];
		write_top_count(4'd1);
		ids = '{16'd0, 16'd7, 16'hFFFF};                 send_profile(ids, 0);
		ids = '{16'd0, 16'd7, 16'h8000, 16'hFFFF};       send_profile(ids, 0);
		ids = {};                                         send_profile(ids, 0);
		ids = '{16'd9, 16'd7, 16'd0};                    send_profile(ids, 0);
		ids = '{16'd0, 16'h5555, 16'hAAAA};              send_profile(ids, 1);
		query_all(5);
		send_query(6'd5);
		send_query('1);
		write_top_count(4'd8);
		query_all(2);
	endtask

	// profiles with nothing in common: average stays zero, lists empty
	task automatic test_disjoint_set();
		logic [ID_W-1:0] ids[$];
		write_top_count(4'd0);
		ids = '{16'd1, 16'd2}; send_profile(ids, 0);
		ids = '{16'd3};        send_profile(ids, 0);
		ids = '{16'd4, 16'd5}; send_profile(ids, 1);
		query_all(3);
	endtask

	// one profile offered more ids than it can hold
	task automatic test_full_profile();
		logic [ID_W-1:0] ids[$];
		write_top_count(4'd15);
		for (int i = 0; i < NLIKE + 3; i++) ids = {ids, ID_W'(i * 2)};
		send_profile(ids, 0);
		ids = '{16'd0, 16'd62, 16'd64, 16'd66}; send_profile(ids, 1);
		query_all(2);
	endtask

	// more profiles than the block stores; the final close still starts the ranking
	task automatic test_profile_overflow();
		logic [ID_W-1:0] ids[$];
		write_top_count(4'd8);
		no_gaps = 1;
		for (int p = 0; p < NPROF + 2; p++) begin
			ids = '{ID_W'(p % 3)};
			send_profile(ids, p == NPROF + 1);
		end
		no_gaps = 0;
		send_query(6'd0);
		send_query(6'd63);
		send_query(6'd31);
	endtask

	// random sets: mostly ascending ids from a small pool, some noise beats
	task automatic test_random_sets(int unsigned beat_goal);
		logic [ID_W-1:0] ids[$];
		logic [ID_W-1:0] base;
		int unsigned n, cnt, step;
		while (beats_sent < beat_goal) begin
			if ($urandom_range(0, 2) == 0) write_top_count($urandom);
			else if ($urandom_range(0, 3) == 0) drain();
			no_gaps = $urandom_range(0, 3) == 0;
			n = $urandom_range(2, 8);
			for (int p = 0; p < n; p++) begin
				ids = {};
				cnt = $urandom_range(0, 6);
				base = ($urandom_range(0, 7) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(0, 3));
				for (int i = 0; i < cnt; i++) begin
					step = $urandom_range(1, 3);
					ids = {ids, base};
					base = base + step;
				end
				if ($urandom_range(0, 15) == 0) ids.shuffle();
				if ($urandom_range(0, 11) == 0)
					send_beat(MODE_UNUSED, $urandom, $urandom, $urandom, $urandom);
				if ($urandom_range(0, 14) == 0) send_query($urandom);
				send_profile(ids, p == n - 1);
			end
			sets_built++;
			for (int k = 0; k < n + 1; k++)
				send_query(($urandom_range(0, 7) == 0) ? PROF_W'($urandom) :
					PROF_W'($urandom_range(0, n - 1)));
		end
	endtask

	initial begin
		errors = 0; beats_sent = 0; entries_seen = 0; sets_built = 0; cycles = 0;
		no_gaps = 0;
		start = 1'b0; mode = MODE_ADD; like_id = '0; last_in_profile = 1'b0;
		last_profile = 1'b0; query_profile = '0; cfg_we = 1'b0; cfg_wdata = '0;
		sh_top_count = TOP_COUNT_RESET;
		drop_set();
		arst_n = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		test_idle_queries();
		test_directed_set();
		test_disjoint_set();
		test_full_profile();
		test_profile_overflow();
		test_random_sets(310);

		drain();
		repeat (50) @(negedge clk);
		$display("ran %0d command beats over %0d random profile sets, checked %0d list entries",
			beats_sent, sets_built, entries_seen);
		$display("top_count swept across its range, overflow, full and empty profiles covered");
		if (errors == 0 && pending_entries.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
